>>> design/assert_macros.svh
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// checked only outside reset
`define CEA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CEA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CEA_ASSERT(lbl, clk, rst_n, prop, msg)
`define CEA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> design/cea_pkg.sv
`timescale 1ns / 1ps

package cea_pkg;

    typedef logic [3:0]  t_mode;
    typedef logic [1:0]  t_rkind;
    typedef logic [15:0] t_addr;
    typedef logic [7:0]  t_byte;

    // addressing modes
    localparam t_mode MODE_IMM = 4'd0;
    localparam t_mode MODE_REL = 4'd1;
    localparam t_mode MODE_ZPG = 4'd2;
    localparam t_mode MODE_ZPX = 4'd3;
    localparam t_mode MODE_ZPY = 4'd4;
    localparam t_mode MODE_ABS = 4'd5;
    localparam t_mode MODE_ABX = 4'd6;
    localparam t_mode MODE_ABY = 4'd7;
    localparam t_mode MODE_IND = 4'd8;
    localparam t_mode MODE_IDX = 4'd9;
    localparam t_mode MODE_IDY = 4'd10;

    // start word vs read data word
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // result kinds
    localparam t_rkind RK_READ  = 2'd0;
    localparam t_rkind RK_DONE  = 2'd1;
    localparam t_rkind RK_ERROR = 2'd2;

    localparam t_addr PAGE_LOW  = 16'h00FF;
    localparam t_addr PAGE_HIGH = 16'hFF00;
    localparam t_byte BYTE_MAX  = 8'hFF;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_OP1    = 3'd1,
        PH_OP2    = 3'd2,
        PH_PTR_LO = 3'd3,
        PH_PTR_HI = 3'd4
    } t_phase;

    typedef struct packed {
        t_rkind result_kind;
        t_addr  read_address;
        t_addr  effective_address;
        t_addr  next_pc;
        logic   extra_cycle;
    } t_result;

endpackage

>>> design/cea_in_if.sv
`timescale 1ns / 1ps

interface cea_in_if;
    import cea_pkg::*;

    logic  valid;
    logic  ready;
    logic  kind;
    t_mode mode;
    t_addr prog_counter;
    t_byte x_index;
    t_byte y_index;
    t_byte read_data;

    modport source (
        output valid, kind, mode, prog_counter, x_index, y_index, read_data,
        input  ready
    );

    modport sink (
        input  valid, kind, mode, prog_counter, x_index, y_index, read_data,
        output ready
    );
endinterface

>>> design/cea_out_if.sv
`timescale 1ns / 1ps

interface cea_out_if;
    import cea_pkg::*;

    logic   valid;
    logic   ready;
    t_rkind result_kind;
    t_addr  read_address;
    t_addr  effective_address;
    t_addr  next_pc;
    logic   extra_cycle;

    modport source (
        output valid, result_kind, read_address, effective_address, next_pc, extra_cycle,
        input  ready
    );

    modport sink (
        input  valid, result_kind, read_address, effective_address, next_pc, extra_cycle,
        output ready
    );
endinterface

>>> design/cpu6502_effective_address_top.sv
`timescale 1ns / 1ps

// 6502 effective-address unit. A start word on i_in carries the addressing mode,
// the pc at the opcode byte, X and Y; each later data word on i_in carries the byte
// read at the address of the last read request. Every input word produces exactly
// one result word on o_out: a read request, a done word with the effective address,
// the next pc and the extra-cycle flag, or an error word (unknown mode, data while
// idle, start while busy, which drops the calculation in progress). Each word is
// decoded against the current phase in a single combinational pass and its result
// is registered, so the result shows in the cycle after acceptance.
// One word is accepted every cycle as long as the result register is empty or is
// being taken in the same cycle; that single output register is what sets the rate.
// IMM completes on its start word, REL and zero-page modes after one data word,
// absolute modes after two, IDX and IDY after three, IND after four. IND keeps the
// page-wrap quirk of the original part when the pointer low byte is 0xFF.

`include "assert_macros.svh"

module cpu6502_effective_address_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cea_in_if.sink      i_in,
    cea_out_if.source   o_out
);
    import cea_pkg::*;

    // sequencing state
    t_phase  r_phase,  n_phase;
    t_mode   r_mode,   n_mode;
    t_addr   r_pc,     n_pc;
    t_byte   r_x,      n_x;
    t_byte   r_y,      n_y;
    t_byte   r_op_low, n_op_low;
    t_byte   r_op_high, n_op_high;
    t_byte   r_ptr_low, n_ptr_low;

    // result register
    logic    r_out_valid;
    t_result r_res, n_res;

    logic    w_in_fire;
    logic    w_busy;
    t_addr   w_word;
    t_addr   w_sum;
    t_byte   w_zp;

    // a new word may enter whenever the result slot is free or drains this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_busy     = (r_phase != PH_IDLE);

    always_comb begin
        n_phase   = r_phase;
        n_mode    = r_mode;
        n_pc      = r_pc;
        n_x       = r_x;
        n_y       = r_y;
        n_op_low  = r_op_low;
        n_op_high = r_op_high;
        n_ptr_low = r_ptr_low;
        n_res     = '0;
        n_res.result_kind = RK_ERROR;
        w_word    = '0;
        w_sum     = '0;
        w_zp      = '0;

        if (i_in.kind == KIND_START) begin
            if (w_busy) begin
                // start while busy: drop the calculation
                n_phase = PH_IDLE;
            end else begin
                n_mode  = i_in.mode;
                n_pc    = i_in.prog_counter;
                n_x     = i_in.x_index;
                n_y     = i_in.y_index;
                n_phase = PH_IDLE;
                if (!(i_in.mode inside {[MODE_IMM:MODE_IDY]})) begin
                    n_res.result_kind = RK_ERROR;
                end else if (i_in.mode == MODE_IMM) begin
                    n_res.result_kind       = RK_DONE;
                    n_res.effective_address = i_in.prog_counter + 16'd1;
                    n_res.next_pc           = i_in.prog_counter + 16'd2;
                end else begin
                    // first operand byte follows the opcode
                    n_phase                 = PH_OP1;
                    n_res.result_kind       = RK_READ;
                    n_res.read_address      = i_in.prog_counter + 16'd1;
                end
            end
        end else if (!w_busy) begin
            // data with no request outstanding
            n_phase = PH_IDLE;
        end else begin
            case (r_phase)
                PH_OP1: begin
                    n_op_low = i_in.read_data;
                    n_phase  = PH_IDLE;
                    case (r_mode)
                        MODE_REL: begin
                            // signed branch offset relative to the following opcode
                            n_res.result_kind       = RK_DONE;
                            n_res.effective_address = r_pc + 16'd2
                                + {{8{i_in.read_data[7]}}, i_in.read_data};
                            n_res.next_pc           = r_pc;
                        end
                        MODE_ZPG: begin
                            n_res.result_kind       = RK_DONE;
                            n_res.effective_address = {8'h00, i_in.read_data};
                            n_res.next_pc           = r_pc + 16'd2;
                        end
                        MODE_ZPX: begin
                            w_zp                    = i_in.read_data + r_x;
                            n_res.result_kind       = RK_DONE;
                            n_res.effective_address = {8'h00, w_zp};
                            n_res.next_pc           = r_pc + 16'd2;
                        end
                        MODE_ZPY: begin
                            w_zp                    = i_in.read_data + r_y;
                            n_res.result_kind       = RK_DONE;
                            n_res.effective_address = {8'h00, w_zp};
                            n_res.next_pc           = r_pc + 16'd2;
                        end
                        MODE_IDX: begin
                            // zero-page pointer wraps within page zero
                            w_zp               = i_in.read_data + r_x;
                            n_op_low           = w_zp;
                            n_phase            = PH_PTR_LO;
                            n_res.result_kind  = RK_READ;
                            n_res.read_address = {8'h00, w_zp};
                        end
                        MODE_IDY: begin
                            n_phase            = PH_PTR_LO;
                            n_res.result_kind  = RK_READ;
                            n_res.read_address = {8'h00, i_in.read_data};
                        end
                        default: begin
                            // absolute forms need the high operand byte
                            n_phase            = PH_OP2;
                            n_res.result_kind  = RK_READ;
                            n_res.read_address = r_pc + 16'd2;
                        end
                    endcase
                end
                PH_OP2: begin
                    n_op_high = i_in.read_data;
                    n_phase   = PH_IDLE;
                    w_word    = {i_in.read_data, r_op_low};
                    case (r_mode)
                        MODE_ABX: begin
                            w_sum                   = w_word + {8'h00, r_x};
                            n_res.result_kind       = RK_DONE;
                            n_res.effective_address = w_sum;
                            n_res.next_pc           = r_pc + 16'd3;
                            n_res.extra_cycle       = (w_sum & PAGE_HIGH) != (w_word & PAGE_HIGH);
                        end
                        MODE_ABY: begin
                            w_sum                   = w_word + {8'h00, r_y};
                            n_res.result_kind       = RK_DONE;
                            n_res.effective_address = w_sum;
                            n_res.next_pc           = r_pc + 16'd3;
                            n_res.extra_cycle       = (w_sum & PAGE_HIGH) != (w_word & PAGE_HIGH);
                        end
                        MODE_IND: begin
                            n_phase            = PH_PTR_LO;
                            n_res.result_kind  = RK_READ;
                            n_res.read_address = w_word;
                        end
                        default: begin
                            n_res.result_kind       = RK_DONE;
                            n_res.effective_address = w_word;
                            n_res.next_pc           = r_pc + 16'd3;
                        end
                    endcase
                end
                PH_PTR_LO: begin
                    n_ptr_low         = i_in.read_data;
                    n_phase           = PH_PTR_HI;
                    n_res.result_kind = RK_READ;
                    w_zp              = r_op_low + 8'd1;
                    if (r_mode == MODE_IND) begin
                        // pointer high byte never leaves the pointer's page
                        n_res.read_address = {r_op_high, w_zp};
                    end else begin
                        n_res.read_address = {8'h00, w_zp};
                    end
                end
                PH_PTR_HI: begin
                    n_phase           = PH_IDLE;
                    w_word            = {i_in.read_data, r_ptr_low};
                    n_res.result_kind = RK_DONE;
                    case (r_mode)
                        MODE_IND: begin
                            n_res.effective_address = w_word;
                            n_res.next_pc           = r_pc + 16'd3;
                            n_res.extra_cycle       = (r_op_low == BYTE_MAX);
                        end
                        MODE_IDY: begin
                            w_sum                   = w_word + {8'h00, r_y};
                            n_res.effective_address = w_sum;
                            n_res.next_pc           = r_pc + 16'd2;
                            n_res.extra_cycle       = (w_sum & PAGE_HIGH) != (w_word & PAGE_HIGH);
                        end
                        default: begin
                            n_res.effective_address = w_word;
                            n_res.next_pc           = r_pc + 16'd2;
                        end
                    endcase
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // held operands and result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IMM;
            r_pc      <= '0;
            r_x       <= '0;
            r_y       <= '0;
            r_op_low  <= '0;
            r_op_high <= '0;
            r_ptr_low <= '0;
            r_res     <= '0;
        end else if (w_in_fire) begin
            r_mode    <= n_mode;
            r_pc      <= n_pc;
            r_x       <= n_x;
            r_y       <= n_y;
            r_op_low  <= n_op_low;
            r_op_high <= n_op_high;
            r_ptr_low <= n_ptr_low;
            r_res     <= n_res;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.result_kind       = r_res.result_kind;
    assign o_out.read_address      = r_res.read_address;
    assign o_out.effective_address = r_res.effective_address;
    assign o_out.next_pc           = r_res.next_pc;
    assign o_out.extra_cycle       = r_res.extra_cycle;

    // an empty result slot never holds off the input
    `CEA_ASSERT_ALWAYS(a_ready_when_empty, i_clk, !r_out_valid |-> i_in.ready, "input stalled with empty result slot")

    // every accepted word leaves a result behind
    `CEA_ASSERT(a_fire_gives_result, i_clk, i_rst_n, w_in_fire |=> o_out.valid, "accepted word produced no result")

    // a pending read request and a busy phase go together
    `CEA_ASSERT(a_phase_matches_result, i_clk, i_rst_n, r_out_valid |-> ((r_res.result_kind == RK_READ) == w_busy), "phase disagrees with last result")

    // only done words may carry the penalty flag
    `CEA_ASSERT(a_extra_only_done, i_clk, i_rst_n, (r_out_valid && r_res.result_kind != RK_DONE) |-> !r_res.extra_cycle, "extra cycle flag on non-done result")

endmodule

>>> dv/cea_address_checker.sv
`timescale 1ns / 1ps

module cea_address_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    cea_in_if    i_req_mon,
    cea_out_if   i_rsp_mon,
    output int   o_pending,
    output int   o_fail_count,
    output int   o_read_count,
    output int   o_done_count,
    output int   o_error_count
);
    import cea_pkg::*;

    // shadow of the unit's sequencing state
    t_phase  phase_q;
    t_mode   mode_q;
    t_addr   pc_q;
    t_byte   x_q;
    t_byte   y_q;
    t_byte   opnd_lo;
    t_byte   opnd_hi;
    t_byte   ptr_lo;

    t_result expected_words[$];

    function automatic t_result read_word(t_addr addr);
        t_result r;
        r = '0;
        r.result_kind  = RK_READ;
        r.read_address = addr;
        return r;
    endfunction

    function automatic t_result done_word(t_addr ea, t_addr npc, logic extra);
        t_result r;
        r = '0;
        r.result_kind       = RK_DONE;
        r.effective_address = ea;
        r.next_pc           = npc;
        r.extra_cycle       = extra;
        return r;
    endfunction

    function automatic logic page_crossed(t_addr a, t_addr b);
        return (a & PAGE_HIGH) != (b & PAGE_HIGH);
    endfunction

    // one accepted word in, one expected result word out
    task automatic predict_address_step(input logic kind, input t_mode mode, input t_addr pc,
                                        input t_byte x, input t_byte y, input t_byte data);
        t_result r;
        t_phase  next;
        t_addr   word;
        t_addr   ea;
        t_byte   zp;
        r = '0;
        r.result_kind = RK_ERROR;
        next = PH_IDLE;
        if (kind == KIND_START) begin
            if (phase_q == PH_IDLE) begin
                mode_q = mode;
                pc_q   = pc;
                x_q    = x;
                y_q    = y;
                if (mode == MODE_IMM) begin
                    r = done_word(pc + 16'd1, pc + 16'd2, 1'b0);
                end else if (mode <= MODE_IDY) begin
                    r = read_word(pc + 16'd1);
                    next = PH_OP1;
                end
            end
        end else begin
            case (phase_q)
                PH_OP1: begin
                    opnd_lo = data;
                    case (mode_q)
                        MODE_REL: r = done_word(pc_q + 16'd2 + {{8{data[7]}}, data}, pc_q, 1'b0);
                        MODE_ZPG: r = done_word({8'h00, data}, pc_q + 16'd2, 1'b0);
                        MODE_ZPX: begin
                            zp = data + x_q;
                            r = done_word({8'h00, zp}, pc_q + 16'd2, 1'b0);
                        end
                        MODE_ZPY: begin
                            zp = data + y_q;
                            r = done_word({8'h00, zp}, pc_q + 16'd2, 1'b0);
                        end
                        MODE_IDX: begin
                            opnd_lo = data + x_q;
                            r = read_word({8'h00, opnd_lo});
                            next = PH_PTR_LO;
                        end
                        MODE_IDY: begin
                            r = read_word({8'h00, data});
                            next = PH_PTR_LO;
                        end
                        default: begin
                            r = read_word(pc_q + 16'd2);
                            next = PH_OP2;
                        end
                    endcase
                end
                PH_OP2: begin
                    opnd_hi = data;
                    word = {opnd_hi, opnd_lo};
                    case (mode_q)
                        MODE_ABX: begin
                            ea = word + x_q;
                            r = done_word(ea, pc_q + 16'd3, page_crossed(ea, word));
                        end
                        MODE_ABY: begin
                            ea = word + y_q;
                            r = done_word(ea, pc_q + 16'd3, page_crossed(ea, word));
                        end
                        MODE_IND: begin
                            r = read_word(word);
                            next = PH_PTR_LO;
                        end
                        default: r = done_word(word, pc_q + 16'd3, 1'b0);
                    endcase
                end
                PH_PTR_LO: begin
                    ptr_lo = data;
                    zp = opnd_lo + 8'd1;
                    // indirect keeps the pointer's page, zero-page pointers wrap in page zero
                    if (mode_q == MODE_IND) r = read_word({opnd_hi, zp});
                    else r = read_word({8'h00, zp});
                    next = PH_PTR_HI;
                end
                PH_PTR_HI: begin
                    word = {data, ptr_lo};
                    if (mode_q == MODE_IND) begin
                        r = done_word(word, pc_q + 16'd3, opnd_lo == BYTE_MAX);
                    end else if (mode_q == MODE_IDY) begin
                        ea = word + y_q;
                        r = done_word(ea, pc_q + 16'd2, page_crossed(ea, word));
                    end else begin
                        r = done_word(word, pc_q + 16'd2, 1'b0);
                    end
                end
                default: ;
            endcase
        end
        phase_q = next;
        expected_words.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            phase_q = PH_IDLE;
            mode_q  = MODE_IMM;
            pc_q    = '0;
            x_q     = '0;
            y_q     = '0;
            opnd_lo = '0;
            opnd_hi = '0;
            ptr_lo  = '0;
            expected_words.delete();
        end else begin
            if (i_req_mon.valid && i_req_mon.ready) begin
                predict_address_step(i_req_mon.kind, i_req_mon.mode, i_req_mon.prog_counter,
                                     i_req_mon.x_index, i_req_mon.y_index,
                                     i_req_mon.read_data);
            end
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t ns: result word with nothing outstanding, kind %0d",
                             $time, i_rsp_mon.result_kind);
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("result_kind", 16'(want.result_kind),
                                16'(i_rsp_mon.result_kind));
                    check_field("read_address", want.read_address, i_rsp_mon.read_address);
                    check_field("effective_address", want.effective_address,
                                i_rsp_mon.effective_address);
                    check_field("next_pc", want.next_pc, i_rsp_mon.next_pc);
                    check_field("extra_cycle", 16'(want.extra_cycle),
                                16'(i_rsp_mon.extra_cycle));
                    case (want.result_kind)
                        RK_READ: o_read_count++;
                        RK_DONE: o_done_count++;
                        default: o_error_count++;
                    endcase
                end
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

>>> dv/tb_cpu6502_effective_address_top.sv
`timescale 1ns / 1ps

module tb_cpu6502_effective_address_top;
    import cea_pkg::*;

    // mode codes the unit must reject
    localparam t_mode MODE_UNUSED_LO = 4'd11;
    localparam t_mode MODE_UNUSED_HI = 4'd15;

    localparam int HOLD_CYCLES  = 80;
    localparam int TOTAL_WORDS  = 540;

    // receiver stall patterns
    typedef enum logic [1:0] {
        SINK_ALWAYS,
        SINK_COIN,
        SINK_EVERY4,
        SINK_MOSTLY
    } t_sink_style;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cea_in_if  in_bus ();
    cea_out_if out_bus ();

    int pending;
    int fail_count;
    int read_count;
    int done_count;
    int error_count;

    int starts_sent;
    int data_sent;
    int burst_left;
    int holds_seen;
    bit hold_req;

    always #6 i_clk = ~i_clk;

    cpu6502_effective_address_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // watches both channels, predicts every result word and compares
    cea_address_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_mon     (in_bus),
        .i_rsp_mon     (out_bus),
        .o_pending     (pending),
        .o_fail_count  (fail_count),
        .o_read_count  (read_count),
        .o_done_count  (done_count),
        .o_error_count (error_count)
    );

    // number of data words a mode consumes after its start word
    function automatic int data_words(t_mode mode);
        case (mode)
            MODE_IMM:                               return 0;
            MODE_REL, MODE_ZPG, MODE_ZPX, MODE_ZPY: return 1;
            MODE_ABS, MODE_ABX, MODE_ABY:           return 2;
            MODE_IDX, MODE_IDY:                     return 3;
            MODE_IND:                               return 4;
            default:                                return 0;
        endcase
    endfunction

    // bytes skewed toward page and sign boundaries
    function automatic t_byte edge_byte();
        case ($urandom_range(0, 7))
            0:       return 8'hFF;
            1:       return 8'h00;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return t_byte'($urandom);
        endcase
    endfunction

    // pc sometimes right at the top of memory to exercise wrap
    function automatic t_addr pick_pc();
        t_addr pc;
        pc = t_addr'($urandom);
        if ($urandom_range(0, 7) == 0) pc = 16'hFFF0 | t_addr'($urandom_range(0, 15));
        return pc;
    endfunction

    // offer one word; bursts of random length, random gaps between them
    task automatic send_word(input logic kind, input t_mode mode, input t_addr pc,
                             input t_byte x, input t_byte y, input t_byte data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                in_bus.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_bus.valid        <= 1'b1;
        in_bus.kind         <= kind;
        in_bus.mode         <= mode;
        in_bus.prog_counter <= pc;
        in_bus.x_index      <= x;
        in_bus.y_index      <= y;
        in_bus.read_data    <= data;
        // wait for the handshake at a rising edge
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        if (kind == KIND_START) starts_sent++;
        else data_sent++;
    endtask

    task automatic send_start(input t_mode mode, input t_addr pc, input t_byte x,
                              input t_byte y);
        send_word(KIND_START, mode, pc, x, y, t_byte'($urandom));
    endtask

    // unused start fields get random junk on data words
    task automatic send_data(input t_byte data);
        send_word(KIND_DATA, t_mode'($urandom_range(0, 15)), t_addr'($urandom),
                  t_byte'($urandom), t_byte'($urandom), data);
    endtask

    // start word then n_data answer bytes, first byte in ops[7:0]
    task automatic run_address(input t_mode mode, input t_addr pc, input t_byte x,
                               input t_byte y, input logic [31:0] ops, input int n_data);
        send_start(mode, pc, x, y);
        for (int i = 0; i < n_data; i++) send_data(ops[8*i +: 8]);
    endtask

    task automatic run_full(input t_mode mode, input t_addr pc, input t_byte x,
                            input t_byte y, input logic [31:0] ops);
        run_address(mode, pc, x, y, ops, data_words(mode));
    endtask

    // sender stops and lets every outstanding result drain
    task automatic drain_pause();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        wait (pending == 0);
        burst_left = 0;
    endtask

    // receiver: stall patterns in stretches, plus a long hold-off on request
    initial begin : receiver
        t_sink_style style;
        int left;
        int tick;
        out_bus.ready = 1'b0;
        style = SINK_ALWAYS;
        left  = 0;
        tick  = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold_req) begin
                // long hold-off so the result register fills and i_in backs up
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
                holds_seen++;
            end else begin
                if (left == 0) begin
                    style = t_sink_style'($urandom_range(0, 3));
                    left  = $urandom_range(20, 60);
                end
                left--;
                case (style)
                    SINK_ALWAYS: out_bus.ready <= 1'b1;
                    SINK_COIN:   out_bus.ready <= 1'($urandom_range(0, 1));
                    SINK_EVERY4: out_bus.ready <= (tick % 4 == 0);
                    default:     out_bus.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int    iter;
        int    choice;
        t_mode mode;
        in_bus.valid        = 1'b0;
        in_bus.kind         = KIND_START;
        in_bus.mode         = MODE_IMM;
        in_bus.prog_counter = '0;
        in_bus.x_index      = '0;
        in_bus.y_index      = '0;
        in_bus.read_data    = '0;
        hold_req   = 1'b0;
        burst_left = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every mode at its wrap and sign corners
        run_full(MODE_IMM, 16'hFFFF, 8'h00, 8'hFF, 32'h0);
        run_full(MODE_REL, 16'hFFFE, 8'h12, 8'h34, 32'h7F);          // forward, pc wraps
        run_full(MODE_REL, 16'h0000, 8'hFF, 8'h00, 32'h80);          // backward, below zero
        run_full(MODE_ZPG, 16'h1234, 8'h00, 8'h00, 32'hFF);
        run_full(MODE_ZPX, 16'h00FE, 8'hFF, 8'h00, 32'h01);          // zero-page wrap on X
        run_full(MODE_ZPY, 16'h8000, 8'h00, 8'h80, 32'h80);          // zero-page wrap on Y
        run_full(MODE_ABS, 16'hFFFE, 8'h00, 8'h00, 32'h8000);        // operand bytes wrap
        run_full(MODE_ABX, 16'h4000, 8'h01, 8'h00, 32'h12FF);        // page cross
        run_full(MODE_ABY, 16'h0100, 8'h00, 8'hFF, 32'hFFFF);        // cross and wrap
        run_full(MODE_IND, 16'hC000, 8'h00, 8'h00, 32'h1234_02FF);   // pointer page quirk
        run_full(MODE_IDX, 16'h0200, 8'h01, 8'h00, 32'h0056_78FE);   // pointer at 0xff
        run_full(MODE_IDY, 16'h0300, 8'h00, 8'hFF, 32'h00FF_01FF);   // cross into page 0
        // error paths: unknown modes, data while idle, start while busy
        send_start(MODE_UNUSED_HI, 16'hFFFF, 8'hFF, 8'hFF);
        send_start(MODE_UNUSED_LO, 16'h0000, 8'h00, 8'h00);
        send_data(8'hA5);
        run_address(MODE_ABS, 16'h1000, 8'h00, 8'h00, 32'h55, 1);
        send_start(MODE_IND, 16'h2000, 8'h00, 8'h00);
        send_data(8'h5A);
        drain_pause();

        // random: mostly complete calculations, some noise and cut-off sequences
        iter = 0;
        while (starts_sent + data_sent < TOTAL_WORDS) begin
            if (iter == 40) hold_req = 1'b1;
            if (iter == 110) drain_pause();
            choice = $urandom_range(0, 99);
            if (choice < 80) begin
                mode = t_mode'($urandom_range(MODE_IMM, MODE_IDY));
                run_full(mode, pick_pc(), edge_byte(), edge_byte(),
                         {edge_byte(), edge_byte(), edge_byte(), edge_byte()});
            end else if (choice < 88) begin
                // interrupted by a fresh start, which errors and idles the unit
                mode = t_mode'($urandom_range(MODE_REL, MODE_IDY));
                run_address(mode, pick_pc(), edge_byte(), edge_byte(), $urandom,
                            $urandom_range(0, data_words(mode) - 1));
                send_start(t_mode'($urandom_range(0, 15)), pick_pc(), edge_byte(),
                           edge_byte());
            end else if (choice < 94) begin
                send_start(t_mode'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)),
                           pick_pc(), edge_byte(), edge_byte());
            end else begin
                send_data(edge_byte());
            end
            iter++;
        end

        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge i_clk);

        $display("run covered all eleven modes, bad modes, stray data and dropped sequences:");
        $display("%0d start and %0d data words in; %0d reads, %0d done, %0d errors, %0d holds",
                 starts_sent, data_sent, read_count, done_count, error_count, holds_seen);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/cea_pkg.sv
design/cea_in_if.sv
design/cea_out_if.sv
design/cpu6502_effective_address_top.sv
dv/cea_address_checker.sv
dv/tb_cpu6502_effective_address_top.sv
